// ===== sv/rita_pkg.sv =====
// shared types, constants and helper functions for the radix integer-to-ascii converter
package rita_pkg;

  localparam int MAX_DIGITS   = 32;
  localparam int VALUE_BITS   = 32;
  localparam int MIN_W_W      = 6;
  localparam int RADIX_W      = 6;
  localparam int CHAR_W       = 7;
  localparam int DIGIT_W      = 6;
  localparam int DIGIT_IDX_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
  localparam int BITCNT_W     = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] DEFAULT_BASE = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] HIGHEST_BASE = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DEC_LIMIT    = DIGIT_W'(9);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_A      = CHAR_W'(65);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [MIN_W_W-1:0]    min_width;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_SEND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd;
    logic idx_dec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic more;
    logic idx_zero;
  } status_t;

  function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < RADIX_W'(2)) b = DEFAULT_BASE;
    else if (r > HIGHEST_BASE) b = HIGHEST_BASE;
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DEC_LIMIT) c = ASCII_A + CHAR_W'(d) - CHAR_W'(10);
    else c = ASCII_ZERO + CHAR_W'(d);
    return c;
  endfunction

endpackage

// ===== sv/rita_ctrl.sv =====
// controller state machine: sequences the division steps, digit stores and character readout
module rita_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_stall,
  input  rita_pkg::status_t status,
  output rita_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import rita_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = status.more ? ST_DIV : ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.idx_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/rita_dp.sv =====
// datapath: radix register, bit-serial divider, digit memory and output character
module rita_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rita_pkg::RADIX_W-1:0] cfg_wdata,
  input  rita_pkg::in_item_t           in_data,
  input  rita_pkg::cmd_t               cmd,
  output rita_pkg::status_t            status,
  output rita_pkg::out_item_t          out_data
);
  import rita_pkg::*;

  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     base_r;
  logic [CNT_W-1:0]       pad_r;
  logic [VALUE_BITS-1:0]  quo_r;
  logic [DIGIT_W-1:0]     rem_r;
  logic [BITCNT_W-1:0]    bitcnt_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [DIGIT_IDX_W-1:0] idx_r;
  logic [DIGIT_W-1:0]     rdata_r;
  logic [DIGIT_W-1:0]     digit_mem [MAX_DIGITS];

  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   trial_sub;
  logic               qbit;
  logic [CNT_W-1:0]   cnt_inc;

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem_r, quo_r[VALUE_BITS-1]};
  assign trial_sub = trial - {1'b0, base_r};
  assign qbit      = (trial >= {1'b0, base_r});
  assign cnt_inc   = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= DEFAULT_BASE;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r    <= '0;
      cnt_r    <= '0;
      bitcnt_r <= '0;
    end else if (cmd.load) begin
      quo_r    <= in_data.value;
      cnt_r    <= '0;
      bitcnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r    <= {quo_r[VALUE_BITS-2:0], qbit};
      bitcnt_r <= bitcnt_r + BITCNT_W'(1);
    end else if (cmd.store) begin
      cnt_r    <= cnt_inc;
      bitcnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= clamp_base(radix_r);
      if ({1'b0, in_data.min_width} > (MIN_W_W + 1)'(MAX_DIGITS)) pad_r <= CNT_W'(MAX_DIGITS);
      else pad_r <= CNT_W'(in_data.min_width);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end else if (cmd.store) begin
      rem_r <= '0;
      idx_r <= cnt_r[DIGIT_IDX_W-1:0];
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - DIGIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) digit_mem[cnt_r[DIGIT_IDX_W-1:0]] <= rem_r;
    if (cmd.rd) rdata_r <= digit_mem[idx_r];
  end

  assign status.div_last = (bitcnt_r == BITCNT_W'(VALUE_BITS - 1));
  // another digit is due while room is left and the quotient or the padding asks for it
  assign status.more     = (cnt_inc < CNT_W'(MAX_DIGITS)) &&
                           ((quo_r != '0) || (cnt_inc < pad_r));
  assign status.idx_zero = (idx_r == '0);

  assign out_data.char_code = char_of(rdata_r);
  assign out_data.last_char = (idx_r == '0);

endmodule

// ===== sv/radix_integer_to_ascii.sv =====
// top level of the radix integer-to-ascii converter
// Usage:
//   Input channel in_valid/in_stall/in_data carries a value and a minimum
//   digit count; a transfer happens when in_valid is high and in_stall low.
//   The result channel out_valid/out_stall/out_data emits one ascii digit per
//   transfer, most significant first, with last_char set on the final digit.
//   cfg_we/cfg_wdata write the number base (reset 10; 0 and 1 act as 10,
//   above 36 acts as 36); write it only while the block is idle.
// Sequencing:
//   one item at a time; in_stall stays high until the last digit of the run
//   has been taken. Each digit is worked out in the bit-serial divider (one
//   quotient bit per cycle, then a store into the digit memory); all digits
//   are stored before the first character is shown. Readout of each
//   character is a registered memory read, then output.
// Reset:
//   synchronous active-low rst_n returns the controller to idle, drops
//   out_valid and restores the base to 10.
// Stall:
//   while out_stall is high the current character holds on out_data.
module radix_integer_to_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rita_pkg::RADIX_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rita_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rita_pkg::out_item_t          out_data
);
  import rita_pkg::*;

  cmd_t    cmd;
  status_t status;

  rita_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  rita_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== sv/rita_checker.sv =====
// port-level checker for the radix integer-to-ascii converter, bound to the top level
module rita_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rita_pkg::out_item_t out_data
);
  import rita_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_no_input_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digits pending");

  a_accept_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("digit shown right after input transfer");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_char |=> !out_valid && !in_stall)
    else $error("run did not end after last digit");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.char_code >= ASCII_ZERO && out_data.char_code <= CHAR_W'(57)) ||
                   (out_data.char_code >= ASCII_A && out_data.char_code <= CHAR_W'(90))))
    else $error("character outside digit range");

endmodule

bind radix_integer_to_ascii rita_checker u_rita_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
